### rtl/core/json_string_scanner_macros.svh
// Assertion helpers shared by the scanner RTL.
// Each one expects a clk and an active-low rst_n in scope.
`ifndef JSON_STRING_SCANNER_MACROS_SVH
`define JSON_STRING_SCANNER_MACROS_SVH

// Condition holds at every edge outside reset.
`define JSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define JSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/jss_pkg.sv
package jss_pkg;

    // Byte values of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    // Result status codes
    localparam logic [1:0] STATUS_MORE = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // Scanner state codes
    localparam int unsigned ST_W = 4;
    localparam logic [ST_W-1:0] ST_INITIAL = 4'd0;
    localparam logic [ST_W-1:0] ST_INSIDE  = 4'd1;
    localparam logic [ST_W-1:0] ST_ESCAPE  = 4'd2;
    localparam logic [ST_W-1:0] ST_CR      = 4'd3;
    localparam logic [ST_W-1:0] ST_LF      = 4'd4;
    localparam logic [ST_W-1:0] ST_HEX1    = 4'd5;
    localparam logic [ST_W-1:0] ST_HEX2    = 4'd6;
    localparam logic [ST_W-1:0] ST_HEX3    = 4'd7;
    localparam logic [ST_W-1:0] ST_HEX4    = 4'd8;
    localparam logic [ST_W-1:0] ST_DONE    = 4'd9;
    localparam logic [ST_W-1:0] ST_FAIL    = 4'd10;

    // Queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    // Classified byte, as handed from front to back
    typedef struct packed {
        logic       restart;
        logic       quote;
        logic       bslash;
        logic       esc_simple;
        logic       low_r;
        logic       low_u;
        logic       low_n;
        logic       hex;
        logic [7:0] ch;
    } jss_item_t;

    function automatic jss_item_t jss_classify(input logic restart, input logic [7:0] c);
        jss_item_t item;
        item.restart    = restart;
        item.quote      = (c == CH_QUOTE);
        item.bslash     = (c == CH_BSLASH);
        item.esc_simple = (c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) ||
                          (c == CH_LOW_B) || (c == CH_LOW_F) || (c == CH_LOW_N) ||
                          (c == CH_LOW_T);
        item.low_r      = (c == CH_LOW_R);
        item.low_u      = (c == CH_LOW_U);
        item.low_n      = (c == CH_LOW_N);
        item.hex        = ((c >= CH_DIG_0) && (c <= CH_DIG_9)) ||
                          ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
                          ((c >= CH_LOW_A) && (c <= CH_LOW_F));
        item.ch         = c;
        return item;
    endfunction

endpackage

### rtl/core/jss_front.sv
module jss_front
    import jss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic      restart,
    input  logic [7:0] char_in,
    input  logic      q_full,
    output logic      push,
    output jss_item_t push_item
);

    logic      front_valid_reg;
    logic      front_valid_next;
    jss_item_t front_item_reg;
    logic      load;

    // Hold off the input only while the stage is full and the queue cannot take it
    assign in_stall  = front_valid_reg && q_full;
    assign load      = in_valid && !in_stall;
    assign push      = front_valid_reg && !q_full;
    assign push_item = front_item_reg;

    // Stage occupancy
    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (load)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Classified byte, captured on each input transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_item_reg <= jss_classify(restart, char_in);
        end
    end

endmodule

### rtl/core/jss_queue.sv
module jss_queue
    import jss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  jss_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output jss_item_t pop_item
);

    jss_item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Occupancy count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/jss_back.sv
`include "json_string_scanner_macros.svh"

module jss_back
    import jss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  jss_item_t  pop_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       append,
    output logic [7:0] char_out
);

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;
    logic [ST_W-1:0] cur_state;
    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic            append_reg;
    logic [7:0]      char_reg;
    logic [1:0]      status_calc;
    logic            append_calc;

    // Take a queued byte when the output register is free or draining
    assign pop = q_valid && (!out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign append    = append_reg;
    assign char_out  = char_reg;

    assign cur_state = pop_item.restart ? ST_INITIAL : state_reg;

    // Literal state machine
    always_comb
    begin
        state_next  = ST_FAIL;
        status_calc = STATUS_MORE;
        append_calc = 1'b1;
        unique case (cur_state)
            ST_INITIAL:
            begin
                if (pop_item.quote)
                begin
                    state_next  = ST_INSIDE;
                    append_calc = 1'b0;
                end
            end
            ST_INSIDE:
            begin
                if (pop_item.quote)
                begin
                    state_next  = ST_DONE;
                    status_calc = STATUS_DONE;
                    append_calc = 1'b0;
                end
                else if (pop_item.bslash)
                begin
                    state_next = ST_ESCAPE;
                end
                else
                begin
                    state_next = ST_INSIDE;
                end
            end
            ST_ESCAPE:
            begin
                if (pop_item.esc_simple)
                begin
                    state_next = ST_INSIDE;
                end
                else if (pop_item.low_r)
                begin
                    state_next = ST_CR;
                end
                else if (pop_item.low_u)
                begin
                    state_next = ST_HEX1;
                end
            end
            ST_CR:
            begin
                if (pop_item.bslash)
                begin
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                if (pop_item.low_n)
                begin
                    state_next = ST_INSIDE;
                end
            end
            ST_HEX1, ST_HEX2, ST_HEX3:
            begin
                if (pop_item.hex)
                begin
                    state_next = cur_state + 1'b1;
                end
            end
            ST_HEX4:
            begin
                if (pop_item.hex)
                begin
                    state_next = ST_INSIDE;
                end
            end
            default:
            begin
                state_next = ST_FAIL;
            end
        endcase
        if (state_next == ST_FAIL)
        begin
            status_calc = STATUS_BAD;
            append_calc = 1'b0;
        end
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INITIAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_calc;
            append_reg <= append_calc;
            char_reg   <= pop_item.ch;
        end
    end

    `JSS_ASSERT_ALWAYS(a_append_only_more, !out_valid_reg || !append_reg || (status_reg == STATUS_MORE), "append set on a non-continuing result")
    `JSS_ASSERT_NEXT(a_done_goes_fail, pop && (state_reg == ST_DONE) && !pop_item.restart, (state_reg == ST_FAIL) && (status_reg == STATUS_BAD), "byte after done not rejected")
    `JSS_ASSERT_NEXT(a_pop_fills_out, pop, out_valid_reg && (char_reg == $past(pop_item.ch)), "popped byte missing from output register")

endmodule

### rtl/core/json_string_scanner.sv
// Channel | Handshake          | Payload
// input   | in_valid, in_stall | restart, char_in
// output  | out_valid, out_stall | status, append, char_out
//
// One byte transfer per cycle sustained on both sides while out_stall stays low.
// Each byte passes the classify register, the two-entry queue and the output register, in that order.
// Reset (rst_n low) empties the pipe and puts the scanner in its initial state.
// in_stall rises only when the classify stage holds a byte and the queue is full;
// an output stall is absorbed by the queue before it reaches the input.

module json_string_scanner
    import jss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       restart,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       append,
    output logic [7:0] char_out
);

    logic      q_full;
    logic      push;
    jss_item_t push_item;
    logic      pop;
    logic      q_valid;
    jss_item_t pop_item;

    jss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .char_in   (char_in),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    jss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    jss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .append    (append),
        .char_out  (char_out)
    );

endmodule

### bench/tb.sv
module tb;
    import jss_pkg::*;

    localparam int DIR_ROWS   = 22;
    localparam int RAND_ITEMS = 1250;

    // One byte as handed to the scanner, with an optional hand-written expectation
    typedef struct packed {
        logic       restart;
        logic [7:0] ch;
        logic       typed;
        logic [1:0] st;
        logic       app;
    } xfer_t;

    typedef struct packed {
        logic [1:0] status;
        logic       append;
        logic [7:0] ch;
    } scan_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       restart = 1'b0;
    logic [7:0] char_in = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic       append;
    logic [7:0] char_out;

    xfer_t        cur_xfer = '0;
    xfer_t        stim_q[$];
    xfer_t        directed_rows[DIR_ROWS];
    scan_result_t expected_scans[$];
    logic [3:0]   lexer_state = ST_INITIAL;

    int mismatch_count = 0;
    int bytes_checked  = 0;
    int literals_done  = 0;
    int bytes_rejected = 0;

    json_string_scanner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .append    (append),
        .char_out  (char_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Lexer prediction: one byte in, one result out, state kept in lexer_state
    function automatic scan_result_t scan_byte(input logic rs, input logic [7:0] c);
        scan_result_t r;
        logic [3:0]   nxt;
        logic         hexd;
        hexd = ((c >= CH_DIG_0) && (c <= CH_DIG_9)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
               ((c >= CH_LOW_A) && (c <= CH_LOW_F));
        nxt      = ST_FAIL;
        r.status = STATUS_MORE;
        r.append = 1'b1;
        r.ch     = c;
        if (rs)
            lexer_state = ST_INITIAL;
        case (lexer_state)
            ST_INITIAL:
            begin
                if (c == CH_QUOTE)
                begin
                    nxt      = ST_INSIDE;
                    r.append = 1'b0;
                end
            end
            ST_INSIDE:
            begin
                if (c == CH_QUOTE)
                begin
                    nxt      = ST_DONE;
                    r.status = STATUS_DONE;
                    r.append = 1'b0;
                end
                else if (c == CH_BSLASH)
                    nxt = ST_ESCAPE;
                else
                    nxt = ST_INSIDE;
            end
            ST_ESCAPE:
            begin
                if ((c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) ||
                    (c == CH_LOW_B) || (c == CH_LOW_F) || (c == CH_LOW_N) ||
                    (c == CH_LOW_T))
                    nxt = ST_INSIDE;
                else if (c == CH_LOW_R)
                    nxt = ST_CR;
                else if (c == CH_LOW_U)
                    nxt = ST_HEX1;
            end
            ST_CR:
            begin
                if (c == CH_BSLASH)
                    nxt = ST_LF;
            end
            ST_LF:
            begin
                if (c == CH_LOW_N)
                    nxt = ST_INSIDE;
            end
            ST_HEX1, ST_HEX2, ST_HEX3:
            begin
                if (hexd)
                    nxt = lexer_state + 4'd1;
            end
            ST_HEX4:
            begin
                if (hexd)
                    nxt = ST_INSIDE;
            end
            default:
            begin
            end
        endcase
        if (nxt == ST_FAIL)
        begin
            r.status = STATUS_BAD;
            r.append = 1'b0;
        end
        lexer_state = nxt;
        return r;
    endfunction

    function automatic xfer_t plain_xfer(input logic rs, input logic [7:0] c);
        xfer_t x;
        x         = '0;
        x.restart = rs;
        x.ch      = c;
        return x;
    endfunction

    function automatic xfer_t typed_xfer(input logic rs, input logic [7:0] c,
                                         input logic [1:0] st, input logic app);
        xfer_t x;
        x       = plain_xfer(rs, c);
        x.typed = 1'b1;
        x.st    = st;
        x.app   = app;
        return x;
    endfunction

    // Predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        scan_result_t exp_r;
        scan_result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_scans.size() == 0)
                begin
                    $error("output transfer with nothing expected: status %0d char %02h",
                           status, char_out);
                    mismatch_count++;
                end
                else
                begin
                    exp_r = expected_scans.pop_front();
                    bytes_checked++;
                    if (status == STATUS_DONE)
                        literals_done++;
                    if (status == STATUS_BAD)
                        bytes_rejected++;
                    if (status !== exp_r.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_r.status, status);
                        mismatch_count++;
                    end
                    if (append !== exp_r.append)
                    begin
                        $error("append mismatch: expected %0d, actual %0d",
                               exp_r.append, append);
                        mismatch_count++;
                    end
                    if (char_out !== exp_r.ch)
                    begin
                        $error("char_out mismatch: expected %02h, actual %02h",
                               exp_r.ch, char_out);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pred = scan_byte(restart, char_in);
                if (cur_xfer.typed)
                begin
                    pred.status = cur_xfer.st;
                    pred.append = cur_xfer.app;
                end
                expected_scans.push_back(pred);
            end
        end
    end

    // Receiver stall: pattern switches among free, sparse, periodic and heavy
    int stall_mode = 0;
    int stall_left = 0;
    int phase_cnt  = 0;

    always @(posedge clk)
    begin
        phase_cnt <= phase_cnt + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 60);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ((phase_cnt % 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Stimulus build and sender
    initial
    begin
        xfer_t      lit[$];
        xfer_t      tmp;
        logic [7:0] esc_letters[7];
        logic [7:0] c;
        int         ntok;
        int         kind;
        int         pos;
        int         gap;
        int         burst_left;
        int         idx;

        esc_letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_T};

        // Directed: open, extremes, one escape of each form, close, after done, failure,
        // escape as first byte, bad escape, bad opening byte
        directed_rows = '{
            typed_xfer(1'b0, CH_QUOTE,  STATUS_MORE, 1'b0),
            typed_xfer(1'b0, 8'h00,     STATUS_MORE, 1'b1),
            typed_xfer(1'b0, 8'hFF,     STATUS_MORE, 1'b1),
            plain_xfer(1'b0, CH_BSLASH),
            plain_xfer(1'b0, CH_QUOTE),
            plain_xfer(1'b0, CH_BSLASH),
            plain_xfer(1'b0, CH_LOW_R),
            plain_xfer(1'b0, CH_BSLASH),
            plain_xfer(1'b0, CH_LOW_N),
            plain_xfer(1'b0, CH_BSLASH),
            plain_xfer(1'b0, CH_LOW_U),
            plain_xfer(1'b0, CH_DIG_0),
            plain_xfer(1'b0, CH_UP_F),
            plain_xfer(1'b0, CH_LOW_A),
            plain_xfer(1'b0, CH_DIG_9),
            typed_xfer(1'b0, CH_QUOTE,  STATUS_DONE, 1'b0),
            typed_xfer(1'b0, 8'h78,     STATUS_BAD,  1'b0),
            typed_xfer(1'b0, 8'h79,     STATUS_BAD,  1'b0),
            typed_xfer(1'b1, CH_QUOTE,  STATUS_MORE, 1'b0),
            plain_xfer(1'b0, CH_BSLASH),
            typed_xfer(1'b0, 8'h71,     STATUS_BAD,  1'b0),
            typed_xfer(1'b1, 8'h00,     STATUS_BAD,  1'b0)
        };
        foreach (directed_rows[i])
            stim_q.push_back(directed_rows[i]);

        // Random literals, mostly well formed, some corrupted
        while (stim_q.size() < DIR_ROWS + RAND_ITEMS)
        begin
            lit.delete();
            lit.push_back(plain_xfer(($urandom_range(0, 9) != 0), CH_QUOTE));
            ntok = $urandom_range(0, 8);
            for (int t = 0; t < ntok; t++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        c = 8'($urandom_range(0, 255));
                        if ((c == CH_QUOTE) || (c == CH_BSLASH))
                            c = c ^ 8'h01;
                        lit.push_back(plain_xfer(1'b0, c));
                    end
                    4, 5:
                    begin
                        lit.push_back(plain_xfer(1'b0, CH_BSLASH));
                        lit.push_back(plain_xfer(1'b0, esc_letters[$urandom_range(0, 6)]));
                    end
                    6:
                    begin
                        lit.push_back(plain_xfer(1'b0, CH_BSLASH));
                        lit.push_back(plain_xfer(1'b0, CH_LOW_R));
                        lit.push_back(plain_xfer(1'b0, CH_BSLASH));
                        lit.push_back(plain_xfer(1'b0, CH_LOW_N));
                    end
                    7, 8:
                    begin
                        lit.push_back(plain_xfer(1'b0, CH_BSLASH));
                        lit.push_back(plain_xfer(1'b0, CH_LOW_U));
                        for (int h = 0; h < 4; h++)
                        begin
                            case ($urandom_range(0, 2))
                                0: c = CH_DIG_0 + 8'($urandom_range(0, 9));
                                1: c = CH_UP_A + 8'($urandom_range(0, 5));
                                default: c = CH_LOW_A + 8'($urandom_range(0, 5));
                            endcase
                            lit.push_back(plain_xfer(1'b0, c));
                        end
                    end
                    default:
                        lit.push_back(plain_xfer(1'b0, 8'($urandom_range(128, 255))));
                endcase
            end
            lit.push_back(plain_xfer(1'b0, CH_QUOTE));

            kind = $urandom_range(0, 99);
            pos  = $urandom_range(0, lit.size() - 1);
            if (kind >= 96)
            begin
                // restart in the middle of a literal
                tmp         = lit[pos];
                tmp.restart = 1'b1;
                lit[pos]    = tmp;
            end
            else if (kind >= 92)
            begin
                // stray bytes after the close
                for (int k = $urandom_range(1, 3); k > 0; k--)
                    lit.push_back(plain_xfer(1'($urandom_range(0, 1)),
                                             8'($urandom_range(0, 255))));
            end
            else if (kind >= 88)
            begin
                // cut short
                while (lit.size() > pos + 1)
                    void'(lit.pop_back());
            end
            else if (kind >= 80)
            begin
                // one corrupted byte
                tmp      = lit[pos];
                tmp.ch   = 8'($urandom_range(0, 255));
                lit[pos] = tmp;
            end
            foreach (lit[i])
                stim_q.push_back(lit[i]);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        for (idx = 0; idx < stim_q.size(); idx++)
        begin
            // drain the pipe after the directed part and halfway through the random part
            if ((idx == DIR_ROWS) || (idx == DIR_ROWS + RAND_ITEMS / 2))
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (expected_scans.size() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 12);
            end
            burst_left--;
            in_valid <= 1'b1;
            restart  <= stim_q[idx].restart;
            char_in  <= stim_q[idx].ch;
            cur_xfer <= stim_q[idx];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;

        // wait out the pipe, then idle on so that any stray transfer is caught
        while (expected_scans.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_scans.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_scans.size());
            mismatch_count++;
        end

        $display("Checked %0d scanned bytes (%0d directed, %0d random) with bursty input",
                 bytes_checked, DIR_ROWS, stim_q.size() - DIR_ROWS);
        $display("and patterned output stall: %0d literals closed, %0d bytes rejected",
                 literals_done, bytes_rejected);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
